### src/lagrsi_pkg.sv
// lagrsi_pkg: shared constants and the controller-to-datapath command bundle
// for the Laguerre filter / RSI block; no dependencies

package lagrsi_pkg;

    // default sizes of the sample path
    localparam int SAMPLE_BITS_DEF   = 24;
    localparam int FRACTION_BITS_DEF = 16;

    // damping register, unsigned Q0.16
    localparam int DAMP_BITS = 16;
    localparam logic [DAMP_BITS-1:0] DAMPING_RESET = {1'b1, {(DAMP_BITS-1){1'b0}}};

    // rsi output, Q0.16 with one extra bit so that 1.0 is representable
    localparam int RSI_FRAC = 16;
    localparam int RSI_BITS = RSI_FRAC + 1;
    localparam logic [RSI_BITS-1:0] RSI_ONE = {1'b1, {RSI_FRAC{1'b0}}};

    // cascade length
    localparam int NUM_STAGES = 4;
    localparam int STAGE_IDX_BITS = 2;

    // commands from the controller to the datapath
    typedef struct packed {
        logic                      load;      // capture sample, apply series start
        logic                      diff;      // form stage difference and base
        logic                      mul_lo;    // low partial product
        logic                      mul_hi;    // high partial product, accumulate
        logic                      upd;       // write stage, rotate cascade
        logic [STAGE_IDX_BITS-1:0] stage;     // stage being worked on
        logic                      fin_a;     // pair sums and adjacent differences
        logic                      fin_b;     // weighted sum, up and down totals
        logic                      fin_c;     // set up both dividers
        logic                      div_step;  // one divider step
        logic                      out_load;  // fill the output register
    } lagrsi_cmd_t;

endpackage

### src/laguerre_filter_rsi.sv
// laguerre_filter_rsi: top level of the Laguerre filter and Laguerre RSI
// block; instantiates lagrsi_ctrl and lagrsi_dp, uses lagrsi_pkg
//
//  channel   | signals                                      | transfer on
//  ----------+----------------------------------------------+-----------------------
//  sample    | sample_valid, sample_ready, price, series_start | valid and ready high
//  result    | result_valid, result_ready, filtered, rsi_value | valid and ready high
//  damping   | damping_we, damping                          | damping_we high
//
// A sample is taken only in idle and then passes, in order, through four stage updates
// (DIFF, MLO, MHI, UPD) on the shared 2-part multiplier, the sums in FA, FB and FC, 16 steps
// of the serial rsi divider (the divide-by-three, a reciprocal multiply in 16-bit
// pieces, runs beside it) and DONE, which fills the result register.
// A new sample is taken while a result still waits; the next result then holds in
// its last cycle and blocks input. Reset clears the cascade, count, flags; damping 0.5.

module laguerre_filter_rsi
    import lagrsi_pkg::*;
#(
    parameter int SAMPLE_BITS   = SAMPLE_BITS_DEF,
    parameter int FRACTION_BITS = FRACTION_BITS_DEF
)(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          sample_valid,
    output logic                          sample_ready,
    input  logic signed [SAMPLE_BITS-1:0] price,
    input  logic                          series_start,
    output logic                          result_valid,
    input  logic                          result_ready,
    output logic signed [SAMPLE_BITS-1:0] filtered,
    output logic [RSI_BITS-1:0]           rsi_value,
    input  logic                          damping_we,
    input  logic [DAMP_BITS-1:0]          damping
);

    lagrsi_cmd_t cmd;

    // sequencer
    lagrsi_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .cmd          (cmd)
    );

    // arithmetic
    lagrsi_dp #(
        .SAMPLE_BITS   (SAMPLE_BITS),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .price        (price),
        .series_start (series_start),
        .damping_we   (damping_we),
        .damping      (damping),
        .filtered     (filtered),
        .rsi_value    (rsi_value)
    );

    // rsi never exceeds 1.0
    ast_rsi_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (rsi_value <= RSI_ONE))
        else $error("rsi_value above 1.0");

    // a transfer starts work, the block is busy on the next cycle
    ast_busy_after_transfer: assert property (@(posedge clk) disable iff (!rst_n)
        (sample_valid && sample_ready) |=> !sample_ready)
        else $error("sample_ready high right after a sample transfer");

    // a new result only appears at the end of a busy period
    ast_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(!sample_ready))
        else $error("result appeared without work in progress");

    // the output register is never reloaded while a result is stalled
    ast_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.out_load && result_valid) |-> result_ready)
        else $error("stalled result overwritten");

endmodule

### src/lagrsi_ctrl.sv
// lagrsi_ctrl: sequencer for the Laguerre filter / RSI block, drives the
// datapath commands and both channel handshakes; depends on lagrsi_pkg

module lagrsi_ctrl
    import lagrsi_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        sample_valid,
    output logic        sample_ready,
    output logic        result_valid,
    input  logic        result_ready,
    output lagrsi_cmd_t cmd
);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_DIFF = 4'd1;
    localparam logic [3:0] S_MLO  = 4'd2;
    localparam logic [3:0] S_MHI  = 4'd3;
    localparam logic [3:0] S_UPD  = 4'd4;
    localparam logic [3:0] S_FA   = 4'd5;
    localparam logic [3:0] S_FB   = 4'd6;
    localparam logic [3:0] S_FC   = 4'd7;
    localparam logic [3:0] S_DIV  = 4'd8;
    localparam logic [3:0] S_DONE = 4'd9;

    localparam int DIV_CNT_BITS = $clog2(RSI_FRAC);
    localparam logic [DIV_CNT_BITS-1:0] DIV_LAST = DIV_CNT_BITS'(RSI_FRAC - 1);
    localparam logic [STAGE_IDX_BITS-1:0] STAGE_LAST = STAGE_IDX_BITS'(NUM_STAGES - 1);

    logic [3:0]                state_reg, state_next;
    logic [STAGE_IDX_BITS-1:0] stage_reg, stage_next;
    logic [DIV_CNT_BITS-1:0]   div_cnt_reg, div_cnt_next;
    logic                      result_valid_reg, result_valid_next;

    // next state and commands
    always_comb
    begin
        state_next   = state_reg;
        stage_next   = stage_reg;
        div_cnt_next = div_cnt_reg;
        cmd          = '0;
        cmd.stage    = stage_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (sample_valid)
                begin
                    cmd.load   = 1'b1;
                    stage_next = '0;
                    state_next = S_DIFF;
                end
            end
            S_DIFF:
            begin
                cmd.diff   = 1'b1;
                state_next = S_MLO;
            end
            S_MLO:
            begin
                cmd.mul_lo = 1'b1;
                state_next = S_MHI;
            end
            S_MHI:
            begin
                cmd.mul_hi = 1'b1;
                state_next = S_UPD;
            end
            S_UPD:
            begin
                cmd.upd = 1'b1;
                if (stage_reg == STAGE_LAST)
                begin
                    state_next = S_FA;
                end
                else
                begin
                    stage_next = stage_reg + 1'b1;
                    state_next = S_DIFF;
                end
            end
            S_FA:
            begin
                cmd.fin_a  = 1'b1;
                state_next = S_FB;
            end
            S_FB:
            begin
                cmd.fin_b  = 1'b1;
                state_next = S_FC;
            end
            S_FC:
            begin
                cmd.fin_c    = 1'b1;
                div_cnt_next = '0;
                state_next   = S_DIV;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (div_cnt_reg == DIV_LAST)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    div_cnt_next = div_cnt_reg + 1'b1;
                end
            end
            S_DONE:
            begin
                // wait for the output register to be free
                if (!result_valid_reg || result_ready)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // output valid flag
    always_comb
    begin
        if (cmd.out_load)
        begin
            result_valid_next = 1'b1;
        end
        else if (result_ready)
        begin
            result_valid_next = 1'b0;
        end
        else
        begin
            result_valid_next = result_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            stage_reg        <= '0;
            div_cnt_reg      <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            stage_reg        <= stage_next;
            div_cnt_reg      <= div_cnt_next;
            result_valid_reg <= result_valid_next;
        end
    end

    assign sample_ready = (state_reg == S_IDLE);
    assign result_valid = result_valid_reg;

endmodule

### src/lagrsi_dp.sv
// lagrsi_dp: datapath of the Laguerre filter / RSI block: rotating stage
// cascade, shared multiplier, rsi divider and reciprocal divide-by-three; uses lagrsi_pkg

module lagrsi_dp
    import lagrsi_pkg::*;
#(
    parameter int SAMPLE_BITS   = SAMPLE_BITS_DEF,
    parameter int FRACTION_BITS = FRACTION_BITS_DEF
)(
    input  logic                          clk,
    input  logic                          rst_n,
    input  lagrsi_cmd_t                   cmd,
    input  logic signed [SAMPLE_BITS-1:0] price,
    input  logic                          series_start,
    input  logic                          damping_we,
    input  logic [DAMP_BITS-1:0]          damping,
    output logic signed [SAMPLE_BITS-1:0] filtered,
    output logic [RSI_BITS-1:0]           rsi_value
);

    // stage and arithmetic widths
    localparam int SW     = SAMPLE_BITS + FRACTION_BITS + 2;  // stage
    localparam int DW     = SW + 1;                           // stage difference
    localparam int LO_W   = (DW + 1) / 2;                     // low split of difference
    localparam int HI_W   = DW - LO_W;
    localparam int MW     = LO_W + 1;                         // multiplier operand
    localparam int GW     = DAMP_BITS + 1;
    localparam int MRW    = MW + GW;                          // multiplier result
    localparam int PW     = DW + DAMP_BITS + 1;               // product accumulator
    localparam int SUMW   = SW + 2;                           // stage update sum
    localparam int CW     = SW + 2;                           // up/down totals
    localparam int TW     = SW + 3;                           // weighted stage sum
    localparam int ZW     = SAMPLE_BITS + 4;                  // sum over 2^(F+1)
    localparam int UW     = ZW + 1;                           // biased dividend
    localparam int D3_CH  = 16;                               // reciprocal piece per step
    localparam int D3_N   = (UW + D3_CH) / D3_CH;             // pieces, D3_CH*D3_N > UW
    localparam int D3_KW  = D3_CH * D3_N;
    localparam int NPAIR  = NUM_STAGES - 1;

    localparam logic [2:0]    IDX_MAX = 3'(NUM_STAGES);
    localparam logic [UW-1:0] D3_BIAS = {2'b11, {(ZW-1){1'b0}}};
    localparam logic [UW-1:0] D3_HALF = {2'b01, {(ZW-1){1'b0}}};
    // ceil(2^D3_KW / 3), exact floor for every dividend below 2^(D3_KW-1)
    localparam logic [D3_KW-1:0] D3_RECIP = D3_KW'((64'd1 << D3_KW) / 64'd3 + 64'd1);

    // registers with reset
    logic [DAMP_BITS-1:0] damping_reg, damping_next;
    logic [2:0]           idx_reg, idx_next;
    logic signed [SW-1:0] st_reg [NUM_STAGES];
    logic signed [SW-1:0] st_next [NUM_STAGES];

    // working registers
    logic signed [SAMPLE_BITS-1:0] price_reg, price_next;
    logic [2:0]                    n_reg, n_next;
    logic signed [SW-1:0]          hold_reg, hold_next;
    logic signed [SW-1:0]          base_reg, base_next;
    logic signed [DW-1:0]          diff_reg, diff_next;
    logic signed [PW-1:0]          acc_reg, acc_next;
    logic signed [SW:0]            sa_reg, sa_next;
    logic signed [SW:0]            sb_reg, sb_next;
    logic [SW-1:0]                 mag_reg [NPAIR];
    logic [SW-1:0]                 mag_next [NPAIR];
    logic [NPAIR-1:0]              up_reg, up_next;
    logic signed [TW-1:0]          t_reg, t_next;
    logic [CW-1:0]                 cu_reg, cu_next;
    logic [CW-1:0]                 cd_reg, cd_next;
    logic [CW-1:0]                 total_reg, total_next;
    logic [CW-1:0]                 rem_reg, rem_next;
    logic [RSI_FRAC-1:0]           q_reg, q_next;
    logic                          rsi_zero_reg, rsi_zero_next;
    logic                          rsi_one_reg, rsi_one_next;
    logic [UW-1:0]                 d3_u_reg, d3_u_next;
    logic [D3_KW-1:0]              d3_m_reg, d3_m_next;
    logic [D3_N-1:0]               d3_left_reg, d3_left_next;
    logic [UW-1:0]                 d3_q_reg, d3_q_next;
    logic signed [SAMPLE_BITS-1:0] filtered_reg, filtered_next;
    logic [RSI_BITS-1:0]           rsi_reg, rsi_next;

    // shared combinational values
    logic signed [SW-1:0]   scaled;
    logic signed [MW-1:0]   mul_a;
    logic signed [GW-1:0]   mul_g;
    logic signed [MRW-1:0]  mul_res;
    logic signed [PW-1:0]   mul_ext;
    logic signed [SUMW-1:0] upd_sum;
    logic signed [SW-1:0]   upd_sat;
    logic                   upd_en;
    logic signed [UW-1:0]   filt_wide;
    logic [UW+D3_CH-1:0]    d3_prod;
    logic [UW+D3_CH:0]      d3_sum;

    // price on the stage scale
    assign scaled = $signed({{2{price_reg[SAMPLE_BITS-1]}}, price_reg, {FRACTION_BITS{1'b0}}});

    // shared multiplier: difference half times damping
    always_comb
    begin
        if (cmd.mul_hi)
        begin
            mul_a = $signed({{(MW-HI_W){diff_reg[DW-1]}}, diff_reg[DW-1:LO_W]});
        end
        else
        begin
            mul_a = $signed({1'b0, diff_reg[LO_W-1:0]});
        end
        mul_g   = $signed({1'b0, damping_reg});
        mul_res = MRW'(mul_a) * MRW'(mul_g);
        mul_ext = PW'(mul_res);
    end

    // stage update with saturation
    always_comb
    begin
        upd_sum = SUMW'(base_reg) + SUMW'(acc_reg >>> DAMP_BITS);
        if ((&upd_sum[SUMW-1:SW-1]) || !(|upd_sum[SUMW-1:SW-1]))
        begin
            upd_sat = upd_sum[SW-1:0];
        end
        else
        begin
            upd_sat = {upd_sum[SUMW-1], {(SW-1){~upd_sum[SUMW-1]}}};
        end
        upd_en = (n_reg > {1'b0, cmd.stage});
    end

    // one piece of the reciprocal product, shifted down as it builds
    always_comb
    begin
        d3_prod = (UW+D3_CH)'(d3_u_reg) * (UW+D3_CH)'(d3_m_reg[D3_CH-1:0]);
        d3_sum  = (UW+D3_CH+1)'(d3_prod) + (UW+D3_CH+1)'(d3_q_reg);
    end

    // filter result from the divide-by-three quotient
    assign filt_wide = $signed(d3_q_reg - D3_HALF);

    // next values
    always_comb
    begin
        logic [CW:0]       two_rem;
        logic signed [SW:0] pdiff;
        logic signed [ZW-1:0] z;

        damping_next  = damping_we ? damping : damping_reg;
        idx_next      = idx_reg;
        st_next       = st_reg;
        price_next    = price_reg;
        n_next        = n_reg;
        hold_next     = hold_reg;
        base_next     = base_reg;
        diff_next     = diff_reg;
        acc_next      = acc_reg;
        sa_next       = sa_reg;
        sb_next       = sb_reg;
        mag_next      = mag_reg;
        up_next       = up_reg;
        t_next        = t_reg;
        cu_next       = cu_reg;
        cd_next       = cd_reg;
        total_next    = total_reg;
        rem_next      = rem_reg;
        q_next        = q_reg;
        rsi_zero_next = rsi_zero_reg;
        rsi_one_next  = rsi_one_reg;
        d3_u_next     = d3_u_reg;
        d3_m_next     = d3_m_reg;
        d3_left_next  = d3_left_reg;
        d3_q_next     = d3_q_reg;
        filtered_next = filtered_reg;
        rsi_next      = rsi_reg;
        two_rem       = {rem_reg, 1'b0};
        pdiff         = '0;
        z             = ZW'(t_reg >>> (FRACTION_BITS + 1));

        // capture sample, a series start clears the cascade first
        if (cmd.load)
        begin
            price_next = price;
            if (series_start)
            begin
                for (int i = 0; i < NUM_STAGES; i++)
                begin
                    st_next[i] = '0;
                end
                n_next   = '0;
                idx_next = 3'd1;
            end
            else
            begin
                n_next   = idx_reg;
                idx_next = (idx_reg == IDX_MAX) ? idx_reg : idx_reg + 1'b1;
            end
        end

        // stage 0 takes the price, later stages the updated stage before them
        if (cmd.diff)
        begin
            if (cmd.stage == '0)
            begin
                diff_next = DW'(st_reg[0]) - DW'(scaled);
                base_next = scaled;
            end
            else
            begin
                diff_next = DW'(st_reg[0]) - DW'(st_reg[NUM_STAGES-1]);
                base_next = hold_reg;
            end
        end

        // two partial products of difference times damping
        if (cmd.mul_lo)
        begin
            acc_next = mul_ext;
        end
        if (cmd.mul_hi)
        begin
            acc_next = acc_reg + (mul_ext <<< LO_W);
        end

        // rotate: the stage just done goes to the back, old value kept
        if (cmd.upd)
        begin
            hold_next = st_reg[0];
            for (int i = 0; i < NUM_STAGES - 1; i++)
            begin
                st_next[i] = st_reg[i+1];
            end
            st_next[NUM_STAGES-1] = upd_en ? upd_sat : st_reg[0];
        end

        // pair sums for the filter, adjacent differences for the rsi
        if (cmd.fin_a)
        begin
            sa_next = (SW+1)'(st_reg[0]) + (SW+1)'(st_reg[3]);
            sb_next = (SW+1)'(st_reg[1]) + (SW+1)'(st_reg[2]);
            for (int i = 0; i < NPAIR; i++)
            begin
                up_next[i] = (st_reg[i] > st_reg[i+1]);
                if (up_next[i])
                begin
                    pdiff = (SW+1)'(st_reg[i]) - (SW+1)'(st_reg[i+1]);
                end
                else
                begin
                    pdiff = (SW+1)'(st_reg[i+1]) - (SW+1)'(st_reg[i]);
                end
                mag_next[i] = pdiff[SW-1:0];
            end
        end

        // weighted sum and up/down totals
        if (cmd.fin_b)
        begin
            t_next  = TW'(sa_reg) + (TW'(sb_reg) <<< 1);
            cu_next = '0;
            cd_next = '0;
            for (int i = 0; i < NPAIR; i++)
            begin
                if (up_reg[i])
                begin
                    cu_next = cu_next + CW'(mag_reg[i]);
                end
                else
                begin
                    cd_next = cd_next + CW'(mag_reg[i]);
                end
            end
        end

        // set up rsi division and the biased divide-by-three
        if (cmd.fin_c)
        begin
            total_next    = cu_reg + cd_reg;
            rem_next      = cu_reg;
            q_next        = '0;
            rsi_zero_next = (cu_reg == '0) && (cd_reg == '0);
            rsi_one_next  = (cd_reg == '0) && (cu_reg != '0);
            d3_u_next     = UW'($unsigned(UW'(z)) + D3_BIAS);
            d3_m_next     = D3_RECIP;
            d3_left_next  = '1;
            d3_q_next     = '0;
        end

        // one restoring step of cu / total, one reciprocal piece of u / 3
        if (cmd.div_step)
        begin
            if (two_rem >= {1'b0, total_reg})
            begin
                rem_next = CW'(two_rem - {1'b0, total_reg});
                q_next   = {q_reg[RSI_FRAC-2:0], 1'b1};
            end
            else
            begin
                rem_next = two_rem[CW-1:0];
                q_next   = {q_reg[RSI_FRAC-2:0], 1'b0};
            end
            if (d3_left_reg[0])
            begin
                d3_q_next    = UW'(d3_sum >> D3_CH);
                d3_m_next    = d3_m_reg >> D3_CH;
                d3_left_next = d3_left_reg >> 1;
            end
        end

        // output register
        if (cmd.out_load)
        begin
            if ((&filt_wide[UW-1:SAMPLE_BITS-1]) || !(|filt_wide[UW-1:SAMPLE_BITS-1]))
            begin
                filtered_next = filt_wide[SAMPLE_BITS-1:0];
            end
            else
            begin
                filtered_next = {filt_wide[UW-1], {(SAMPLE_BITS-1){~filt_wide[UW-1]}}};
            end
            if (rsi_zero_reg)
            begin
                rsi_next = '0;
            end
            else if (rsi_one_reg)
            begin
                rsi_next = RSI_ONE;
            end
            else
            begin
                rsi_next = {1'b0, q_reg};
            end
        end
    end

    // configuration and series state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            damping_reg <= DAMPING_RESET;
            idx_reg     <= '0;
            for (int i = 0; i < NUM_STAGES; i++)
            begin
                st_reg[i] <= '0;
            end
        end
        else
        begin
            damping_reg <= damping_next;
            idx_reg     <= idx_next;
            st_reg      <= st_next;
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        price_reg    <= price_next;
        n_reg        <= n_next;
        hold_reg     <= hold_next;
        base_reg     <= base_next;
        diff_reg     <= diff_next;
        acc_reg      <= acc_next;
        sa_reg       <= sa_next;
        sb_reg       <= sb_next;
        mag_reg      <= mag_next;
        up_reg       <= up_next;
        t_reg        <= t_next;
        cu_reg       <= cu_next;
        cd_reg       <= cd_next;
        total_reg    <= total_next;
        rem_reg      <= rem_next;
        q_reg        <= q_next;
        rsi_zero_reg <= rsi_zero_next;
        rsi_one_reg  <= rsi_one_next;
        d3_u_reg     <= d3_u_next;
        d3_m_reg     <= d3_m_next;
        d3_left_reg  <= d3_left_next;
        d3_q_reg     <= d3_q_next;
        filtered_reg <= filtered_next;
        rsi_reg      <= rsi_next;
    end

    assign filtered  = filtered_reg;
    assign rsi_value = rsi_reg;

endmodule
